FILE: hdl/scrb_pkg.sv
// ----------------------------------------------------------------------------
// scrb_pkg: shared types and constants of the scancode ring buffer
// Item codes, modifier modes, scancodes, the mode update function and the
// control/status structs between the core and the ring.
// ----------------------------------------------------------------------------
`default_nettype none

package scrb_pkg;

  localparam int BUFFER_LAST_DEF = 15;

  localparam int CODE_W  = 7;
  localparam int MODE_W  = 3;
  localparam int CHAR_W  = 8;
  localparam int SCAN_W  = 8;
  localparam int KIND_W  = 2;

  // Table columns: one per mode code below TABLE_COLS, the top mode code is unused.
  localparam logic [MODE_W-1:0] TABLE_COLS = 3'd7;

  typedef enum logic [KIND_W-1:0] {
    KIND_SCAN  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_TABLE = 2'd2
  } kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LOOK = 1'b1
  } state_e;

  localparam logic [MODE_W-1:0] MODE_PLAIN      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SHIFT      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CTRL       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ALT        = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CAPS       = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CAPS_SHIFT = 3'd6;

  localparam logic [CODE_W-1:0] SC_LSHIFT = 7'h2a;
  localparam logic [CODE_W-1:0] SC_RSHIFT = 7'h36;
  localparam logic [CODE_W-1:0] SC_CTRL   = 7'h1d;
  localparam logic [CODE_W-1:0] SC_ALT    = 7'h38;
  localparam logic [CODE_W-1:0] SC_CAPS   = 7'h3a;

  // Input beat as held inside the core
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SCAN_W-1:0] scan_byte;
    logic [CODE_W-1:0] entry_code;
    logic [MODE_W-1:0] entry_mode;
    logic [CHAR_W-1:0] entry_char;
  } item_t;

  typedef struct packed {
    logic rd_en;  // fetch slot at read pointer
    logic push;   // append one character
    logic pop;    // drop oldest character
  } ring_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ring_sts_t;

  // Mode after a scancode (break bit in the top bit of the byte).
  function automatic logic [MODE_W-1:0] next_mode(input logic [MODE_W-1:0] mode,
                                                  input logic [SCAN_W-1:0] scan);
    logic [CODE_W-1:0] code;
    logic [MODE_W-1:0] res;
    code = scan[CODE_W-1:0];
    res  = mode;
    if (!scan[SCAN_W-1]) begin
      case (code)
        SC_LSHIFT, SC_RSHIFT: res = (mode >= MODE_CAPS) ? MODE_CAPS_SHIFT : MODE_SHIFT;
        SC_CTRL:              res = MODE_CTRL;
        SC_ALT:               res = MODE_ALT;
        SC_CAPS:              res = (mode != MODE_PLAIN) ? MODE_PLAIN : MODE_CAPS;
        default:              res = mode;
      endcase
    end else begin
      case (code)
        SC_LSHIFT, SC_RSHIFT, SC_CTRL, SC_ALT:
          res = (mode == MODE_CAPS_SHIFT) ? MODE_CAPS : MODE_PLAIN;
        default: res = mode;
      endcase
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/scrb_item_if.sv
// ----------------------------------------------------------------------------
// scrb_item_if: input channel of the scancode ring buffer
// Valid/ready channel carrying one scancode, read or table write beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface scrb_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] scan_byte;
  logic [6:0] entry_code;
  logic [2:0] entry_mode;
  logic [7:0] entry_char;

  modport source (output valid, kind, scan_byte, entry_code, entry_mode, entry_char,
                  input  ready);
  modport sink   (input  valid, kind, scan_byte, entry_code, entry_mode, entry_char,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/scrb_result_if.sv
// ----------------------------------------------------------------------------
// scrb_result_if: result channel of the scancode ring buffer
// Valid/ready channel carrying one result beat per input beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface scrb_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_char;
  logic       char_stored;
  logic       buffer_full;
  logic [2:0] mode_now;

  modport source (output valid, read_char, char_stored, buffer_full, mode_now,
                  input  ready);
  modport sink   (input  valid, read_char, char_stored, buffer_full, mode_now,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/scrb_ring.sv
// ----------------------------------------------------------------------------
// scrb_ring: character ring with one-slot-free full rule
// Synchronous memory of BUFFER_LAST+1 slots, read data registered, plus the
// read and write pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module scrb_ring #(
  parameter int BUFFER_LAST = scrb_pkg::BUFFER_LAST_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  scrb_pkg::ring_ctl_t          ctl_i,
  input  wire [scrb_pkg::CHAR_W-1:0]   wdata_i,
  output logic [scrb_pkg::CHAR_W-1:0] rdata_o,
  output scrb_pkg::ring_sts_t          sts_o
);

  localparam int Depth = BUFFER_LAST + 1;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(BUFFER_LAST);

  logic [scrb_pkg::CHAR_W-1:0] mem [Depth];
  logic [scrb_pkg::CHAR_W-1:0] rdata_q;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] wr_next, rd_next;

  assign wr_next = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
  assign rd_next = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;

  assign sts_o.empty = (wr_ptr_q == rd_ptr_q);
  assign sts_o.full  = (wr_next == rd_ptr_q);

  always_comb begin
    wr_ptr_d = ctl_i.push ? wr_next : wr_ptr_q;
    rd_ptr_d = ctl_i.pop  ? rd_next : rd_ptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  assign rdata_o = rdata_q;

  // Pointers never leave the slot range
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_ptr_q <= PtrLast) && (wr_ptr_q <= PtrLast))
    else $error("ring pointer out of range");

  // A push without a pop always leaves at least one character behind
  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push && !ctl_i.pop |=> !sts_o.empty)
    else $error("ring empty after push");

endmodule

`default_nettype wire

FILE: hdl/scancode_to_char_ring_buffer_core.sv
// ----------------------------------------------------------------------------
// scancode_to_char_ring_buffer_core: keyboard scancode translator and buffer
// Tracks the modifier mode, translates make codes through a loadable
// 128x7 character table and queues nonzero characters in a ring.
// ----------------------------------------------------------------------------
//
//  channel   | modport               | beat carries
//  ----------+-----------------------+-----------------------------------------
//  item_i    | scrb_item_if.sink     | kind, scan_byte, entry_code/mode/char
//  result_o  | scrb_result_if.source | read_char, char_stored, buffer_full,
//            |                       | mode_now (one beat per item beat)
//
//  Steps: the accept cycle launches the table read (row =
//  make code, column = updated mode) and the ring read at the read pointer;
//  the LOOK state sees both registered outputs and commits ring, pointers,
//  mode, table write and the result beat.
//  Stalls: a commit waits while the result register is held by the sink; a
//  new item is taken as soon as the previous one committed, even while its
//  result beat still waits.
//  Reset: clears pointers, mode and handshake state only. The table must be
//  loaded with table-write beats before scancodes are sent.
// ----------------------------------------------------------------------------
`default_nettype none

module scancode_to_char_ring_buffer_core #(
  parameter int BUFFER_LAST = scrb_pkg::BUFFER_LAST_DEF
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  scrb_item_if.sink     item_i,
  scrb_result_if.source result_o
);

  // table address = {make code, mode}; mode column 7 is never used
  localparam int TblAw    = scrb_pkg::CODE_W + scrb_pkg::MODE_W;
  localparam int TblDepth = 2 ** TblAw;

  scrb_pkg::state_e state_q, state_d;
  scrb_pkg::item_t  item_q;

  logic [scrb_pkg::MODE_W-1:0] mode_q, mode_d;

  // character table
  logic [scrb_pkg::CHAR_W-1:0] tbl_mem [TblDepth];
  logic [scrb_pkg::CHAR_W-1:0] tbl_rdata_q;
  logic [TblAw-1:0]            tbl_raddr;
  logic [TblAw-1:0]            tbl_waddr;
  logic                        tbl_we;

  // ring
  scrb_pkg::ring_ctl_t         ring_ctl;
  scrb_pkg::ring_sts_t         ring_sts;
  logic [scrb_pkg::CHAR_W-1:0] ring_rdata;

  // result register
  logic                        out_valid_q, out_valid_d;
  logic [scrb_pkg::CHAR_W-1:0] out_char_q;
  logic                        out_stored_q;
  logic                        out_full_q;
  logic [scrb_pkg::MODE_W-1:0] out_mode_q;

  logic accept, out_free, commit;
  logic is_scan, is_make, is_read, is_tbl;
  logic drop, stored, rd_hit;
  logic [scrb_pkg::MODE_W-1:0] mode_upd;

  assign item_i.ready = (state_q == scrb_pkg::ST_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign out_free     = !out_valid_q || result_o.ready;
  assign commit       = (state_q == scrb_pkg::ST_LOOK) && out_free;

  // decode of the held item
  assign is_scan  = (item_q.kind == scrb_pkg::KIND_SCAN);
  assign is_read  = (item_q.kind == scrb_pkg::KIND_READ);
  assign is_tbl   = (item_q.kind == scrb_pkg::KIND_TABLE);
  assign is_make  = is_scan && !item_q.scan_byte[scrb_pkg::SCAN_W-1];
  assign mode_upd = scrb_pkg::next_mode(mode_q, item_q.scan_byte);

  // full ring drops make codes and keeps the mode; breaks still apply
  assign drop   = is_make && ring_sts.full;
  assign stored = is_make && !ring_sts.full && (tbl_rdata_q != '0);
  assign rd_hit = is_read && !ring_sts.empty;

  // table lookup launched at accept with the mode the item will produce
  assign tbl_raddr = {item_i.scan_byte[scrb_pkg::CODE_W-1:0],
                      scrb_pkg::next_mode(mode_q, item_i.scan_byte)};
  assign tbl_waddr = {item_q.entry_code, item_q.entry_mode};
  assign tbl_we    = commit && is_tbl && (item_q.entry_mode < scrb_pkg::TABLE_COLS);

  always_comb begin
    ring_ctl.rd_en = accept;
    ring_ctl.push  = commit && stored;
    ring_ctl.pop   = commit && rd_hit;
  end

  // next state and mode
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    out_valid_d = out_valid_q;
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      scrb_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = scrb_pkg::ST_LOOK;
        end
      end
      scrb_pkg::ST_LOOK: begin
        if (commit) begin
          state_d     = scrb_pkg::ST_IDLE;
          out_valid_d = 1'b1;
          if (is_scan && !drop) begin
            mode_d = mode_upd;
          end
        end
      end
      default: begin
        state_d = scrb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scrb_pkg::ST_IDLE;
      mode_q      <= scrb_pkg::MODE_PLAIN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.kind       <= item_i.kind;
      item_q.scan_byte  <= item_i.scan_byte;
      item_q.entry_code <= item_i.entry_code;
      item_q.entry_mode <= item_i.entry_mode;
      item_q.entry_char <= item_i.entry_char;
    end
    if (commit) begin
      out_char_q   <= rd_hit ? ring_rdata : '0;
      out_stored_q <= stored;
      out_full_q   <= drop;
      out_mode_q   <= mode_d;
    end
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= item_q.entry_char;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tbl_rdata_q <= tbl_mem[tbl_raddr];
    end
  end

  scrb_ring #(
    .BUFFER_LAST (BUFFER_LAST)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ring_ctl),
    .wdata_i (tbl_rdata_q),
    .rdata_o (ring_rdata),
    .sts_o   (ring_sts)
  );

  assign result_o.valid       = out_valid_q;
  assign result_o.read_char   = out_char_q;
  assign result_o.char_stored = out_stored_q;
  assign result_o.buffer_full = out_full_q;
  assign result_o.mode_now    = out_mode_q;

  // mode 4 and code 7 are never entered
  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q <= scrb_pkg::MODE_ALT) || (mode_q == scrb_pkg::MODE_CAPS) ||
    (mode_q == scrb_pkg::MODE_CAPS_SHIFT))
    else $error("illegal modifier mode");

  // an accepted beat is committed in the following cycle or later, never skipped
  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == scrb_pkg::ST_LOOK))
    else $error("accepted beat not in lookup");

  // a result beat never reports a stored and a dropped character together
  a_result_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_stored_q && out_full_q))
    else $error("stored and dropped in one beat");

  // mode only moves on a committing scancode beat
  a_mode_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(commit && is_scan) |=> $stable(mode_q))
    else $error("mode changed outside scancode commit");

endmodule

`default_nettype wire
